// ===== rtl/core/mrs_pkg.sv =====
// mrs_pkg: payload structs, operation and function codes, limits and crc helper
// for the modbus rtu slave responder; no dependencies
package mrs_pkg;

  typedef struct packed {
    logic [2:0]  operation;
    logic [7:0]  rx_byte;
    logic        frame_error;
    logic [1:0]  table_select;
    logic [6:0]  table_index;
    logic [15:0] table_value;
  } mrs_in_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  tx_byte;
    logic        tx_last;
    logic [15:0] read_value;
  } mrs_out_t;

  typedef enum logic [2:0] {
    OP_RX_BYTE   = 3'd0,
    OP_END_FRAME = 3'd1,
    OP_PULL      = 3'd2,
    OP_LOCAL_WR  = 3'd3,
    OP_LOCAL_RD  = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    K_RX_BYTE,
    K_END_FRAME,
    K_PULL,
    K_LOCAL_WR,
    K_LOCAL_RD,
    K_NOP
  } kind_e;

  typedef struct packed {
    logic    valid;
    kind_e   kind;
    mrs_in_t item;
  } head_t;

  typedef struct packed {
    logic       clearing;
  } back_status_t;

  typedef struct packed {
    logic [7:0] slave_address;
    logic       one_based;
  } cfg_t;

  localparam logic CFG_SLAVE_ADDRESS = 1'b0;
  localparam logic CFG_ONE_BASED     = 1'b1;

  localparam logic RK_REPLY = 1'b0;
  localparam logic RK_LOCAL = 1'b1;

  localparam logic [1:0] SEL_COIL     = 2'd0;
  localparam logic [1:0] SEL_DISCRETE = 2'd1;
  localparam logic [1:0] SEL_INPUT    = 2'd2;
  localparam logic [1:0] SEL_HOLDING  = 2'd3;

  localparam logic [7:0] FC_RD_COILS    = 8'h01;
  localparam logic [7:0] FC_RD_DISCRETE = 8'h02;
  localparam logic [7:0] FC_RD_HOLDING  = 8'h03;
  localparam logic [7:0] FC_RD_INPUT    = 8'h04;
  localparam logic [7:0] FC_WR_COILS    = 8'h0F;
  localparam logic [7:0] FC_WR_REGS     = 8'h10;
  localparam logic [7:0] EXC_FLAG       = 8'h80;

  localparam logic [7:0] EXC_NONE     = 8'h00;
  localparam logic [7:0] EXC_FUNCTION = 8'h01;
  localparam logic [7:0] EXC_RANGE    = 8'h02;
  localparam logic [7:0] EXC_COUNT    = 8'h03;

  localparam logic [15:0] MAX_BITS     = 16'h07D0;
  localparam logic [15:0] MAX_RD_REGS  = 16'h007D;
  localparam logic [15:0] MAX_WR_REGS  = 16'h007B;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  function automatic logic [15:0] crc_byte(logic [15:0] c, logic [7:0] d);
    logic [15:0] x;
    x = c ^ {8'h00, d};
    for (int k = 0; k < 8; k++) begin
      x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
    end
    return x;
  endfunction

endpackage

// ===== rtl/core/modbus_rtu_slave_responder.sv =====
// modbus_rtu_slave_responder: top level with configuration registers, the
// front queue and the back sequencer; depends on mrs_pkg, mrs_front, mrs_back
//
// usage
//   in channel: one beat per operation (received byte, end of frame, pull
//   reply byte, local table write, local table read); accepted when in_valid
//   is high and in_stall is low. a two-entry queue sits behind the port.
//   out channel: one beat per pulled reply byte or local read; held in an
//   output register until out_stall is low, so a stalled receiver only
//   blocks the sequencer once it has the next result ready.
//   config port: cfg_we writes cfg_data into register cfg_index (0 slave
//   address, 1 one-based addressing) at the clock edge.
// sequence
//   received byte: S_RXW; local write: S_LWR. local read: S_LRA, then S_LRD
//   loads the output register; reply pull: S_TXA, then S_TXD likewise.
//   end of frame: S_HA/S_HD per header byte, S_DEC, then S_H0, S_H1 and
//   S_EXC, S_BCNT or S_ECHO for the reply header; then S_RB_A/S_RB_D per
//   read bit, S_RR_A/H/L per read register, S_WC_A/D per written coil,
//   S_WR_A/H/L per written register, S_CRC_A/D per reply byte for the crc
//   pass, and S_CRC_L/H for the crc bytes; each memory read is registered.
// reset
//   synchronous rst clears control state, then a clearing pass (S_CLR) over
//   every table index zeroes the four tables; in_stall is high meanwhile.
module modbus_rtu_slave_responder #(
  parameter int TABLE_DEPTH = 128,
  parameter int FRAME_BYTES = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  mrs_pkg::mrs_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output mrs_pkg::mrs_out_t out_data,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [7:0]        cfg_data
);

  mrs_pkg::cfg_t         cfg;
  mrs_pkg::head_t        head;
  mrs_pkg::back_status_t status;
  logic                  pop;

  // configuration registers, written any time without handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slave_address <= 8'd1;
      cfg.one_based     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        mrs_pkg::CFG_SLAVE_ADDRESS: cfg.slave_address <= cfg_data;
        mrs_pkg::CFG_ONE_BASED:     cfg.one_based     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // front: accept and classify beats into the queue
  mrs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .status   (status),
    .head     (head),
    .pop      (pop)
  );

  // back: execute operations and drive the output register
  mrs_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .FRAME_BYTES (FRAME_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head      (head),
    .pop       (pop),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/core/mrs_front.sv =====
// mrs_front: accepts input beats, classifies the operation and holds them in
// a two-entry queue for the back end; depends on mrs_pkg
module mrs_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  mrs_pkg::mrs_in_t      in_data,
  input  mrs_pkg::back_status_t status,
  output mrs_pkg::head_t        head,
  input  logic                  pop
);

  mrs_pkg::mrs_in_t q_item [2];
  mrs_pkg::kind_e   q_kind [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       take;
  mrs_pkg::kind_e in_kind;

  always_comb begin
    case (in_data.operation)
      mrs_pkg::OP_RX_BYTE:   in_kind = mrs_pkg::K_RX_BYTE;
      mrs_pkg::OP_END_FRAME: in_kind = mrs_pkg::K_END_FRAME;
      mrs_pkg::OP_PULL:      in_kind = mrs_pkg::K_PULL;
      mrs_pkg::OP_LOCAL_WR:  in_kind = mrs_pkg::K_LOCAL_WR;
      mrs_pkg::OP_LOCAL_RD:  in_kind = mrs_pkg::K_LOCAL_RD;
      default:               in_kind = mrs_pkg::K_NOP;
    endcase
  end

  assign in_stall = (fill == 2'd2) || status.clearing;
  assign push     = in_valid && !in_stall;
  assign take     = pop && (fill != 2'd0);

  assign head.valid = (fill != 2'd0);
  assign head.kind  = q_kind[rd_ptr];
  assign head.item  = q_item[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_item[wr_ptr] <= in_data;
      q_kind[wr_ptr] <= in_kind;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (take) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, take};
    end
  end

endmodule

// ===== rtl/core/mrs_back.sv =====
// mrs_back: sequencer that executes queued operations against the frame,
// table and reply memories, builds replies with crc, and drives the output
// register; depends on mrs_pkg
module mrs_back #(
  parameter int TABLE_DEPTH = 128,
  parameter int FRAME_BYTES = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  mrs_pkg::cfg_t         cfg,
  input  mrs_pkg::head_t        head,
  output logic                  pop,
  output mrs_pkg::back_status_t status,
  output logic                  out_valid,
  input  logic                  out_stall,
  output mrs_pkg::mrs_out_t     out_data
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int FW = $clog2(FRAME_BYTES);
  localparam int CW = $clog2(FRAME_BYTES + 1);
  localparam int NW = 13;
  localparam logic [16:0] BIT_LIMIT = 17'(TABLE_DEPTH * 8);
  localparam logic [16:0] REG_LIMIT = 17'(TABLE_DEPTH);

  typedef enum logic [29:0] {
    S_CLR   = 30'd1 << 0,
    S_IDLE  = 30'd1 << 1,
    S_RXW   = 30'd1 << 2,
    S_LWR   = 30'd1 << 3,
    S_LRA   = 30'd1 << 4,
    S_LRD   = 30'd1 << 5,
    S_TXA   = 30'd1 << 6,
    S_TXD   = 30'd1 << 7,
    S_HA    = 30'd1 << 8,
    S_HD    = 30'd1 << 9,
    S_DEC   = 30'd1 << 10,
    S_H0    = 30'd1 << 11,
    S_H1    = 30'd1 << 12,
    S_EXC   = 30'd1 << 13,
    S_BCNT  = 30'd1 << 14,
    S_ECHO  = 30'd1 << 15,
    S_RB_A  = 30'd1 << 16,
    S_RB_D  = 30'd1 << 17,
    S_RR_A  = 30'd1 << 18,
    S_RR_H  = 30'd1 << 19,
    S_RR_L  = 30'd1 << 20,
    S_WC_A  = 30'd1 << 21,
    S_WC_D  = 30'd1 << 22,
    S_WR_A  = 30'd1 << 23,
    S_WR_H  = 30'd1 << 24,
    S_WR_L  = 30'd1 << 25,
    S_CRC_A = 30'd1 << 26,
    S_CRC_D = 30'd1 << 27,
    S_CRC_L = 30'd1 << 28,
    S_CRC_H = 30'd1 << 29
  } state_e;

  state_e state, state_next;

  // control and working registers
  logic [NW-1:0]    cnt, cnt_next;
  mrs_pkg::mrs_in_t cur, cur_next;
  logic [7:0]       hdr [7];
  logic [15:0]      addr_r, addr_next;
  logic [10:0]      num_r, num_next;
  logic [7:0]       fc_r, fc_next;
  logic [7:0]       exc_r, exc_next;
  logic [7:0]       nb_r, nb_next;
  logic [8:0]       nlen, nlen_next;
  logic [15:0]      crc, crc_next;
  logic [7:0]       acc, acc_next;
  logic [CW-1:0]    rx_count, rx_count_next;
  logic [8:0]       tx_len, tx_len_next;
  logic [8:0]       tx_pos, tx_pos_next;
  logic             hdr_we;
  logic             out_free;
  logic             out_load;
  mrs_pkg::mrs_out_t out_next;

  // memories
  logic [7:0]  rx_mem   [FRAME_BYTES];
  logic [7:0]  tx_mem   [256];
  logic [7:0]  coil_mem [TABLE_DEPTH];
  logic [7:0]  disc_mem [TABLE_DEPTH];
  logic [15:0] inr_mem  [TABLE_DEPTH];
  logic [15:0] hold_mem [TABLE_DEPTH];

  logic          rx_we;
  logic [8:0]    rx_ix;
  logic          rx_ok, rx_okq;
  logic [7:0]    rx_rd, rx_val;
  logic          tx_we;
  logic [7:0]    tx_wa, tx_wd, tx_ra, tx_rd;
  logic [AW-1:0] tab_wa, tab_ra;
  logic          coil_we, disc_we, inr_we, hold_we;
  logic [7:0]    coil_wd;
  logic [15:0]   hold_wd;
  logic [15:0]   tab_wd;
  logic [7:0]    coil_rd, disc_rd;
  logic [15:0]   inr_rd, hold_rd;

  // decode helpers
  logic [16:0] span;
  logic [16:0] bit_addr;
  logic        idx_ok;
  logic        last;
  logic        bit_val;
  logic [7:0]  bit_byte;
  logic [7:0]  sel_byte;
  logic [7:0]  coil_new;
  logic [15:0] addr_c, num_c;
  logic [16:0] nbyte_c;
  logic [7:0]  exc_c;
  logic [15:0] sel_rd;

  assign status.clearing = (state == S_CLR);
  assign out_free = !out_valid || !out_stall;
  assign rx_val   = rx_okq ? rx_rd : 8'h00;
  assign bit_addr = {1'b0, addr_r} + 17'(cnt);
  assign idx_ok   = ({6'd0, cur.table_index} < 13'(TABLE_DEPTH));
  assign last     = (cnt == NW'(num_r) - NW'(1));
  assign sel_byte = (fc_r == mrs_pkg::FC_RD_COILS) ? coil_rd : disc_rd;
  assign bit_val  = sel_byte[bit_addr[2:0]];
  assign bit_byte = acc | (8'(bit_val) << cnt[2:0]);

  always_comb begin
    coil_new = coil_rd;
    coil_new[bit_addr[2:0]] = rx_val[cnt[2:0]];
  end

  always_comb begin
    case (cur.table_select)
      mrs_pkg::SEL_COIL:     sel_rd = {8'h00, coil_rd};
      mrs_pkg::SEL_DISCRETE: sel_rd = {8'h00, disc_rd};
      mrs_pkg::SEL_INPUT:    sel_rd = inr_rd;
      default:               sel_rd = hold_rd;
    endcase
  end

  // request decode over the captured header
  always_comb begin
    addr_c  = {hdr[2], hdr[3]} - {15'd0, cfg.one_based};
    num_c   = {hdr[4], hdr[5]};
    span    = {1'b0, addr_c} + {1'b0, num_c};
    nbyte_c = ({1'b0, num_c} + 17'd7) >> 3;
    exc_c   = mrs_pkg::EXC_NONE;
    case (hdr[1])
      mrs_pkg::FC_RD_COILS, mrs_pkg::FC_RD_DISCRETE: begin
        if (num_c == 16'd0 || num_c > mrs_pkg::MAX_BITS) exc_c = mrs_pkg::EXC_COUNT;
        else if (span > BIT_LIMIT) exc_c = mrs_pkg::EXC_RANGE;
      end
      mrs_pkg::FC_RD_HOLDING, mrs_pkg::FC_RD_INPUT: begin
        if (num_c == 16'd0 || num_c > mrs_pkg::MAX_RD_REGS) exc_c = mrs_pkg::EXC_COUNT;
        else if (span > REG_LIMIT) exc_c = mrs_pkg::EXC_RANGE;
      end
      mrs_pkg::FC_WR_COILS: begin
        if (num_c == 16'd0 || num_c > mrs_pkg::MAX_BITS ||
            nbyte_c != {9'd0, hdr[6]}) exc_c = mrs_pkg::EXC_COUNT;
        else if (span > BIT_LIMIT) exc_c = mrs_pkg::EXC_RANGE;
      end
      mrs_pkg::FC_WR_REGS: begin
        if (num_c == 16'd0 || num_c > mrs_pkg::MAX_WR_REGS ||
            {1'b0, num_c, 1'b0} != {10'd0, hdr[6]}) exc_c = mrs_pkg::EXC_COUNT;
        else if (span > REG_LIMIT) exc_c = mrs_pkg::EXC_RANGE;
      end
      default: exc_c = mrs_pkg::EXC_FUNCTION;
    endcase
  end

  // memory address and write selection
  always_comb begin
    rx_ix   = 9'd0;
    tx_we   = 1'b0;
    tx_wa   = 8'd0;
    tx_wd   = 8'd0;
    tx_ra   = 8'(tx_pos);
    tab_ra  = AW'(bit_addr);
    tab_wa  = AW'(cur.table_index);
    tab_wd  = cur.table_value;
    coil_wd = cur.table_value[7:0];
    hold_wd = cur.table_value;
    coil_we = 1'b0;
    disc_we = 1'b0;
    inr_we  = 1'b0;
    hold_we = 1'b0;
    rx_we   = (state == S_RXW) && (rx_count < CW'(FRAME_BYTES));
    case (state)
      S_CLR: begin
        tab_wa  = AW'(cnt);
        tab_wd  = 16'h0000;
        coil_wd = 8'h00;
        hold_wd = 16'h0000;
        coil_we = 1'b1;
        disc_we = 1'b1;
        inr_we  = 1'b1;
        hold_we = 1'b1;
      end
      S_LWR: begin
        coil_we = idx_ok && (cur.table_select == mrs_pkg::SEL_COIL);
        disc_we = idx_ok && (cur.table_select == mrs_pkg::SEL_DISCRETE);
        inr_we  = idx_ok && (cur.table_select == mrs_pkg::SEL_INPUT);
        hold_we = idx_ok && (cur.table_select == mrs_pkg::SEL_HOLDING);
      end
      S_LRA, S_LRD: tab_ra = AW'(cur.table_index);
      S_HA, S_HD:   rx_ix  = 9'(cnt[2:0]);
      S_H0: begin
        tx_we = 1'b1;
        tx_wa = 8'd0;
        tx_wd = cfg.slave_address;
      end
      S_H1: begin
        tx_we = 1'b1;
        tx_wa = 8'd1;
        tx_wd = (exc_r != mrs_pkg::EXC_NONE) ? fc_r + mrs_pkg::EXC_FLAG : fc_r;
      end
      S_EXC: begin
        tx_we = 1'b1;
        tx_wa = 8'd2;
        tx_wd = exc_r;
      end
      S_BCNT: begin
        tx_we = 1'b1;
        tx_wa = 8'd2;
        tx_wd = (fc_r == mrs_pkg::FC_RD_COILS || fc_r == mrs_pkg::FC_RD_DISCRETE) ?
                nb_r : 8'({num_r, 1'b0});
      end
      S_ECHO: begin
        tx_we = 1'b1;
        tx_wa = 8'd2 + 8'(cnt[1:0]);
        tx_wd = hdr[3'd2 + 3'(cnt[1:0])];
      end
      S_RB_D: begin
        tx_we = (cnt[2:0] == 3'd7) || last;
        tx_wa = 8'(NW'(3) + (cnt >> 3));
        tx_wd = bit_byte;
      end
      S_RR_H: begin
        tx_we = 1'b1;
        tx_wa = 8'(NW'(3) + (cnt << 1));
        tx_wd = (fc_r == mrs_pkg::FC_RD_HOLDING) ? hold_rd[15:8] : inr_rd[15:8];
      end
      S_RR_L: begin
        tx_we = 1'b1;
        tx_wa = 8'(NW'(4) + (cnt << 1));
        tx_wd = (fc_r == mrs_pkg::FC_RD_HOLDING) ? hold_rd[7:0] : inr_rd[7:0];
      end
      S_WC_A: begin
        rx_ix  = 9'(NW'(7) + (cnt >> 3));
        tab_ra = AW'(bit_addr >> 3);
      end
      S_WC_D: begin
        rx_ix   = 9'(NW'(7) + (cnt >> 3));
        tab_ra  = AW'(bit_addr >> 3);
        tab_wa  = AW'(bit_addr >> 3);
        coil_wd = coil_new;
        coil_we = 1'b1;
      end
      S_WR_A: rx_ix = 9'(NW'(7) + (cnt << 1));
      S_WR_H: rx_ix = 9'(NW'(8) + (cnt << 1));
      S_WR_L: begin
        rx_ix   = 9'(NW'(8) + (cnt << 1));
        tab_wa  = AW'(bit_addr);
        hold_wd = {acc, rx_val};
        hold_we = 1'b1;
      end
      S_CRC_A, S_CRC_D: tx_ra = 8'(cnt);
      S_CRC_L: begin
        tx_we = 1'b1;
        tx_wa = 8'(nlen);
        tx_wd = crc[7:0];
      end
      S_CRC_H: begin
        tx_we = 1'b1;
        tx_wa = 8'(nlen + 9'd1);
        tx_wd = crc[15:8];
      end
      default: ;
    endcase
    // bit reads address the byte that holds the bit
    if (state == S_RB_A || state == S_RB_D) tab_ra = AW'(bit_addr >> 3);
    rx_ok = (rx_ix < 9'(rx_count));
  end

  always_ff @(posedge clk) begin
    if (rx_we) rx_mem[FW'(rx_count)] <= cur.rx_byte;
    rx_rd  <= rx_mem[FW'(rx_ix)];
    rx_okq <= rx_ok;
  end

  always_ff @(posedge clk) begin
    if (tx_we) tx_mem[tx_wa] <= tx_wd;
    tx_rd <= tx_mem[tx_ra];
  end

  always_ff @(posedge clk) begin
    if (coil_we) coil_mem[tab_wa] <= coil_wd;
    coil_rd <= coil_mem[tab_ra];
  end

  always_ff @(posedge clk) begin
    if (disc_we) disc_mem[tab_wa] <= tab_wd[7:0];
    disc_rd <= disc_mem[tab_ra];
  end

  always_ff @(posedge clk) begin
    if (inr_we) inr_mem[tab_wa] <= tab_wd;
    inr_rd <= inr_mem[tab_ra];
  end

  always_ff @(posedge clk) begin
    if (hold_we) hold_mem[tab_wa] <= hold_wd;
    hold_rd <= hold_mem[tab_ra];
  end

  // sequencer
  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    cur_next      = cur;
    addr_next     = addr_r;
    num_next      = num_r;
    fc_next       = fc_r;
    exc_next      = exc_r;
    nb_next       = nb_r;
    nlen_next     = nlen;
    crc_next      = crc;
    acc_next      = acc;
    rx_count_next = rx_count;
    tx_len_next   = tx_len;
    tx_pos_next   = tx_pos;
    hdr_we        = 1'b0;
    pop           = 1'b0;
    out_load      = 1'b0;
    out_next      = '0;
    case (state)
      S_CLR: begin
        if (cnt == NW'(TABLE_DEPTH - 1)) begin
          cnt_next   = '0;
          state_next = S_IDLE;
        end else begin
          cnt_next = cnt + NW'(1);
        end
      end
      S_IDLE: begin
        if (head.valid) begin
          pop      = 1'b1;
          cur_next = head.item;
          cnt_next = '0;
          case (head.kind)
            mrs_pkg::K_RX_BYTE: state_next = S_RXW;
            mrs_pkg::K_END_FRAME: begin
              if (head.item.frame_error || rx_count < CW'(2)) rx_count_next = '0;
              else state_next = S_HA;
            end
            mrs_pkg::K_PULL:     if (tx_pos < tx_len) state_next = S_TXA;
            mrs_pkg::K_LOCAL_WR: state_next = S_LWR;
            mrs_pkg::K_LOCAL_RD: state_next = S_LRA;
            default: ;
          endcase
        end
      end
      S_RXW: begin
        if (rx_we) rx_count_next = rx_count + CW'(1);
        state_next = S_IDLE;
      end
      S_LWR: state_next = S_IDLE;
      S_LRA: state_next = S_LRD;
      S_LRD: begin
        if (out_free) begin
          out_load            = 1'b1;
          out_next.result_kind = mrs_pkg::RK_LOCAL;
          out_next.read_value  = idx_ok ? sel_rd : 16'h0000;
          state_next          = S_IDLE;
        end
      end
      S_TXA: state_next = S_TXD;
      S_TXD: begin
        if (out_free) begin
          out_load             = 1'b1;
          out_next.result_kind = mrs_pkg::RK_REPLY;
          out_next.tx_byte     = tx_rd;
          out_next.tx_last     = (tx_pos + 9'd1 == tx_len);
          tx_pos_next          = tx_pos + 9'd1;
          state_next           = S_IDLE;
        end
      end
      S_HA: state_next = S_HD;
      S_HD: begin
        hdr_we = 1'b1;
        if (cnt == NW'(6)) begin
          state_next = S_DEC;
        end else begin
          cnt_next   = cnt + NW'(1);
          state_next = S_HA;
        end
      end
      S_DEC: begin
        cnt_next = '0;
        if (hdr[0] != cfg.slave_address) begin
          rx_count_next = '0;
          state_next    = S_IDLE;
        end else begin
          addr_next  = addr_c;
          num_next   = 11'(num_c);
          fc_next    = hdr[1];
          exc_next   = exc_c;
          nb_next    = 8'(nbyte_c);
          state_next = S_H0;
        end
      end
      S_H0: state_next = S_H1;
      S_H1: begin
        if (exc_r != mrs_pkg::EXC_NONE) state_next = S_EXC;
        else if (fc_r == mrs_pkg::FC_WR_COILS || fc_r == mrs_pkg::FC_WR_REGS)
          state_next = S_ECHO;
        else state_next = S_BCNT;
      end
      S_EXC: begin
        nlen_next  = 9'd3;
        crc_next   = mrs_pkg::CRC_INIT;
        state_next = S_CRC_A;
      end
      S_BCNT: begin
        acc_next = 8'h00;
        if (fc_r == mrs_pkg::FC_RD_COILS || fc_r == mrs_pkg::FC_RD_DISCRETE) begin
          nlen_next  = 9'd3 + {1'b0, nb_r};
          state_next = S_RB_A;
        end else begin
          nlen_next  = 9'd3 + 9'({num_r, 1'b0});
          state_next = S_RR_A;
        end
      end
      S_ECHO: begin
        if (cnt == NW'(3)) begin
          cnt_next   = '0;
          nlen_next  = 9'd6;
          state_next = (fc_r == mrs_pkg::FC_WR_COILS) ? S_WC_A : S_WR_A;
        end else begin
          cnt_next = cnt + NW'(1);
        end
      end
      S_RB_A: state_next = S_RB_D;
      S_RB_D: begin
        acc_next = ((cnt[2:0] == 3'd7) || last) ? 8'h00 : bit_byte;
        if (last) begin
          cnt_next   = '0;
          crc_next   = mrs_pkg::CRC_INIT;
          state_next = S_CRC_A;
        end else begin
          cnt_next   = cnt + NW'(1);
          state_next = S_RB_A;
        end
      end
      S_RR_A: state_next = S_RR_H;
      S_RR_H: state_next = S_RR_L;
      S_RR_L: begin
        if (last) begin
          cnt_next   = '0;
          crc_next   = mrs_pkg::CRC_INIT;
          state_next = S_CRC_A;
        end else begin
          cnt_next   = cnt + NW'(1);
          state_next = S_RR_A;
        end
      end
      S_WC_A: state_next = S_WC_D;
      S_WC_D: begin
        if (last) begin
          cnt_next   = '0;
          crc_next   = mrs_pkg::CRC_INIT;
          state_next = S_CRC_A;
        end else begin
          cnt_next   = cnt + NW'(1);
          state_next = S_WC_A;
        end
      end
      S_WR_A: state_next = S_WR_H;
      S_WR_H: begin
        acc_next   = rx_val;
        state_next = S_WR_L;
      end
      S_WR_L: begin
        if (last) begin
          cnt_next   = '0;
          crc_next   = mrs_pkg::CRC_INIT;
          state_next = S_CRC_A;
        end else begin
          cnt_next   = cnt + NW'(1);
          state_next = S_WR_A;
        end
      end
      S_CRC_A: state_next = S_CRC_D;
      S_CRC_D: begin
        crc_next = mrs_pkg::crc_byte(crc, tx_rd);
        if (cnt == NW'(nlen) - NW'(1)) begin
          state_next = S_CRC_L;
        end else begin
          cnt_next   = cnt + NW'(1);
          state_next = S_CRC_A;
        end
      end
      S_CRC_L: state_next = S_CRC_H;
      S_CRC_H: begin
        tx_len_next   = nlen + 9'd2;
        tx_pos_next   = 9'd0;
        rx_count_next = '0;
        state_next    = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    cur    <= cur_next;
    addr_r <= addr_next;
    num_r  <= num_next;
    fc_r   <= fc_next;
    exc_r  <= exc_next;
    nb_r   <= nb_next;
    nlen   <= nlen_next;
    crc    <= crc_next;
    acc    <= acc_next;
    if (hdr_we) hdr[cnt[2:0]] <= rx_val;
    if (out_load) out_data <= out_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      cnt       <= '0;
      rx_count  <= '0;
      tx_len    <= '0;
      tx_pos    <= '0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      rx_count <= rx_count_next;
      tx_len   <= tx_len_next;
      tx_pos   <= tx_pos_next;
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLR) |-> !pop)
    else $error("queue popped during clearing pass");
  a_load_only_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || !out_stall))
    else $error("output register overwritten while stalled");
  a_pos_le_len: assert property (@(posedge clk) disable iff (rst)
    tx_pos <= tx_len)
    else $error("reply position beyond reply length");
  a_rx_bound: assert property (@(posedge clk) disable iff (rst)
    rx_count <= CW'(FRAME_BYTES))
    else $error("receive count beyond frame store");
  a_pull_advances: assert property (@(posedge clk) disable iff (rst)
    (state == S_TXD && out_free) |=> (tx_pos == $past(tx_pos) + 9'd1))
    else $error("reply pull did not advance position");
`endif

endmodule
